// File: rtl/flp_pkg.sv
// Package for the fixed-point line projection unit.
// Shared constants, types and helpers; no dependencies.
package flp_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CoordW = 32;
  localparam int unsigned AlphaW = 9;
  localparam int unsigned CenterW = 12;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = 2;
  localparam int unsigned DivStages = 32;

  localparam logic [CfgIdxW-1:0] REG_R0_01 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_R0_23 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_R1_01 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_R1_23 = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_R2_01 = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_R2_23 = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_CX = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_CY = 3'd7;

  localparam logic signed [CoordW-1:0] NEAR_LIMIT = 32'sh0000_0400;
  localparam logic [CoordW-1:0] FAR_OFFSET = 32'h0000_2000;

  // Item handed from the transform front end to the divider back end.
  typedef struct packed {
    logic draw;
    logic [CoordW-1:0] nx;
    logic [CoordW-1:0] ny;
    logic [CoordW-1:0] depth;
    logic [AlphaW-1:0] alpha;
  } proj_item_t;

  typedef struct packed {
    logic draw;
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] start_y;
    logic [CoordW-1:0] end_x;
    logic [CoordW-1:0] end_y;
    logic [AlphaW-1:0] alpha;
  } proj_res_t;

  // Product of a coordinate and a matrix entry, shifted right by 8, low 32 bits.
  function automatic logic [CoordW-1:0] scaled_term(input logic [63:0] prod);
    scaled_term = prod[CoordW+7:8];
  endfunction

endpackage

// File: rtl/flp_front.sv
// Front end: 3x4 matrix transform, near-plane classification.
// Depends on flp_pkg. Three register stages, one point per cycle unless stalled.
module flp_front import flp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic [CfgDataW-1:0] mat_r [6],
  input  logic in_valid,
  input  logic [CoordW-1:0] x_in,
  input  logic [CoordW-1:0] y_in,
  input  logic [CoordW-1:0] z_in,
  input  logic [AlphaW-1:0] alpha_in,
  input  logic stall,
  output logic out_valid,
  output proj_item_t out_item
);

  logic v1_r, v2_r, v3_r;
  logic [CoordW-1:0] x1_r, y1_r, z1_r;
  logic [AlphaW-1:0] a1_r, a2_r;
  logic [63:0] prod_r [3][3];
  logic [CoordW-1:0] sum_nxt [3];
  proj_item_t item_r;

  assign out_valid = v3_r;
  assign out_item = item_r;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_nxt[r] = mat_r[2*r+1][63:32] + scaled_term(prod_r[r][0])
                 + scaled_term(prod_r[r][1]) + scaled_term(prod_r[r][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (!stall) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      x1_r <= {{8{x_in[CoordW-1]}}, x_in[CoordW-1:8]};
      y1_r <= {{8{y_in[CoordW-1]}}, y_in[CoordW-1:8]};
      z1_r <= {{8{z_in[CoordW-1]}}, z_in[CoordW-1:8]};
      a1_r <= alpha_in;
      for (int r = 0; r < 3; r++) begin
        prod_r[r][0] <= 64'($signed(x1_r) * $signed(mat_r[2*r][31:0]));
        prod_r[r][1] <= 64'($signed(y1_r) * $signed(mat_r[2*r][63:32]));
        prod_r[r][2] <= 64'($signed(z1_r) * $signed(mat_r[2*r+1][31:0]));
      end
      a2_r <= a1_r;
      item_r.draw <= ($signed(sum_nxt[2]) >= NEAR_LIMIT);
      item_r.nx <= {sum_nxt[0][CoordW-9:0], 8'h00};
      item_r.ny <= {sum_nxt[1][CoordW-9:0], 8'h00};
      item_r.depth <= sum_nxt[2];
      item_r.alpha <= a2_r;
    end
  end

endmodule

// File: rtl/flp_queue.sv
// Short queue between front and back ends, also the result queue.
// Depends on flp_pkg. Registered storage, QDepth entries.
module flp_queue import flp_pkg::*; #(
  parameter int unsigned Width = 1
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  logic [Width-1:0] wdata,
  input  logic pop,
  output logic [Width-1:0] rdata,
  output logic empty,
  output logic full,
  output logic almost_full
);

  logic [Width-1:0] mem_r [QDepth];
  logic [QPtrW-1:0] wp_r, rp_r;
  logic [QPtrW:0] cnt_r;
  logic do_push, do_pop;

  assign empty = (cnt_r == '0);
  assign full = (cnt_r == (QPtrW+1)'(QDepth));
  assign almost_full = (cnt_r >= (QPtrW+1)'(QDepth - 1));
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QPtrW+1)'(do_push) - (QPtrW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wdata;
  end

endmodule

// File: rtl/flp_back.sv
// Back end: four pipelined restoring dividers and the screen offsets.
// Depends on flp_pkg. One bit per stage, between an input and an output register.
module flp_back import flp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic [CenterW-1:0] cx,
  input  logic [CenterW-1:0] cy,
  input  logic in_valid,
  input  proj_item_t in_item,
  input  logic stall,
  output logic out_valid,
  output proj_res_t out_res
);

  localparam int unsigned N = DivStages;
  localparam int unsigned Lanes = 4;

  // Per lane: remainder, quotient bits, magnitude of divisor, sign of the quotient.
  logic [N-1:0] num_r [N+1][Lanes];
  logic [N:0] rem_r [N+1][Lanes];
  logic [N-1:0] div_r [N+1][Lanes];
  logic neg_r [N+1][Lanes];
  logic v_r [N+1];
  logic draw_r [N+1];
  logic [AlphaW-1:0] a_r [N+1];
  logic v_out_r;
  proj_res_t res_r;
  logic [CoordW-1:0] far_w;
  logic [CoordW-1:0] nums [Lanes];
  logic [CoordW-1:0] dens [Lanes];
  logic [N:0] trial [N][Lanes];
  logic [CoordW-1:0] q [Lanes];

  assign far_w = in_item.depth + FAR_OFFSET;
  assign nums[0] = in_item.nx;
  assign nums[1] = in_item.ny;
  assign nums[2] = in_item.nx;
  assign nums[3] = in_item.ny;
  assign dens[0] = in_item.depth;
  assign dens[1] = in_item.depth;
  assign dens[2] = far_w;
  assign dens[3] = far_w;

  always_comb begin
    for (int s = 0; s < N; s++) begin
      for (int l = 0; l < Lanes; l++) begin
        trial[s][l] = {rem_r[s][l][N-1:0], num_r[s][l][N-1]} - {1'b0, div_r[s][l]};
      end
    end
    for (int l = 0; l < Lanes; l++) begin
      q[l] = neg_r[N][l] ? (~num_r[N][l] + 1'b1) : num_r[N][l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= N; s++) v_r[s] <= 1'b0;
      v_out_r <= 1'b0;
    end else if (!stall) begin
      v_r[0] <= in_valid;
      for (int s = 0; s < N; s++) v_r[s+1] <= v_r[s];
      v_out_r <= v_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      draw_r[0] <= in_item.draw;
      a_r[0] <= in_item.alpha;
      for (int l = 0; l < Lanes; l++) begin
        num_r[0][l] <= nums[l][N-1] ? (~nums[l] + 1'b1) : nums[l];
        div_r[0][l] <= dens[l][N-1] ? (~dens[l] + 1'b1) : dens[l];
        neg_r[0][l] <= nums[l][N-1] ^ dens[l][N-1];
        rem_r[0][l] <= '0;
      end
      for (int s = 0; s < N; s++) begin
        draw_r[s+1] <= draw_r[s];
        a_r[s+1] <= a_r[s];
        for (int l = 0; l < Lanes; l++) begin
          div_r[s+1][l] <= div_r[s][l];
          neg_r[s+1][l] <= neg_r[s][l];
          if (!trial[s][l][N]) begin
            rem_r[s+1][l] <= trial[s][l];
            num_r[s+1][l] <= {num_r[s][l][N-2:0], 1'b1};
          end else begin
            rem_r[s+1][l] <= {rem_r[s][l][N-1:0], num_r[s][l][N-1]};
            num_r[s+1][l] <= {num_r[s][l][N-2:0], 1'b0};
          end
        end
      end
      res_r.draw <= draw_r[N];
      res_r.alpha <= a_r[N];
      res_r.start_x <= draw_r[N] ? CoordW'(cx) + q[0] : '0;
      res_r.start_y <= draw_r[N] ? CoordW'(cy) - q[1] : '0;
      res_r.end_x <= draw_r[N] ? CoordW'(cx) + q[2] : '0;
      res_r.end_y <= draw_r[N] ? CoordW'(cy) - q[3] : '0;
    end
  end

  assign out_valid = v_out_r;
  assign out_res = res_r;

endmodule

// File: rtl/fixed_point_line_projection_unit.sv
// Fixed-point line projection unit: top level.
// Order: front end, middle queue, divider back end, result queue.
// One point per cycle unless stalled; the four pipelined 32-stage dividers set the depth.
// Reset: synchronous active-low rst_n clears all valid state and the
// configuration registers to zero. Depends on flp_pkg and all flp_ modules.
module fixed_point_line_projection_unit import flp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic push,
  output logic full,
  input  logic [CoordW-1:0] in_point_x,
  input  logic [CoordW-1:0] in_point_y,
  input  logic [CoordW-1:0] in_point_z,
  input  logic [AlphaW-1:0] in_line_alpha,
  output logic empty,
  input  logic pop,
  output logic out_draw_line,
  output logic [CoordW-1:0] out_start_x,
  output logic [CoordW-1:0] out_start_y,
  output logic [CoordW-1:0] out_end_x,
  output logic [CoordW-1:0] out_end_y,
  output logic [AlphaW-1:0] out_alpha_out
);

  logic [CfgDataW-1:0] mat_r [6];
  logic [CenterW-1:0] cx_r, cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) mat_r[i] <= '0;
      cx_r <= '0;
      cy_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_R0_01, REG_R0_23, REG_R1_01, REG_R1_23, REG_R2_01, REG_R2_23:
          mat_r[cfg_index] <= cfg_data;
        REG_CX: cx_r <= cfg_data[CenterW-1:0];
        REG_CY: cy_r <= cfg_data[CenterW-1:0];
        default: ;
      endcase
    end
  end

  // The back end halts as a whole when the result queue is nearly full, so
  // the item in its last stage always finds room. The front end halts on its
  // own when the middle queue is full; frozen items wait in place.
  logic fv, bv, mid_empty, mid_full, mid_af, res_full, res_af, stall, front_stall;
  proj_item_t f_item, m_item;
  proj_res_t b_res, o_res;

  assign stall = res_af;
  assign front_stall = mid_full;
  assign full = front_stall;

  flp_front u_front (
    .clk, .rst_n, .mat_r,
    .in_valid(push && !full),
    .x_in(in_point_x), .y_in(in_point_y), .z_in(in_point_z),
    .alpha_in(in_line_alpha),
    .stall(front_stall),
    .out_valid(fv), .out_item(f_item)
  );

  flp_queue #(.Width($bits(proj_item_t))) u_mid (
    .clk, .rst_n,
    .push(fv && !mid_full), .wdata(f_item),
    .pop(!stall && !mid_empty), .rdata(m_item),
    .empty(mid_empty), .full(mid_full), .almost_full(mid_af)
  );

  flp_back u_back (
    .clk, .rst_n, .cx(cx_r), .cy(cy_r),
    .in_valid(!mid_empty && !stall), .in_item(m_item),
    .stall(stall),
    .out_valid(bv), .out_res(b_res)
  );

  flp_queue #(.Width($bits(proj_res_t))) u_res (
    .clk, .rst_n,
    .push(bv && !stall), .wdata(b_res),
    .pop(pop), .rdata(o_res),
    .empty(empty), .full(res_full), .almost_full(res_af)
  );

  logic unused_full;
  assign unused_full = mid_af ^ res_full;

  assign out_draw_line = o_res.draw;
  assign out_start_x = o_res.start_x;
  assign out_start_y = o_res.start_y;
  assign out_end_x = o_res.end_x;
  assign out_end_y = o_res.end_y;
  assign out_alpha_out = o_res.alpha;

endmodule

// File: test/flp_projection_checker.sv
// Checker for the fixed-point line projection unit: mirrors the configuration writes,
// predicts each projected line and compares it with what the unit delivers.
// Depends on flp_pkg.
`timescale 1ns / 1ps
module flp_projection_checker import flp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic push,
  input  logic full,
  input  logic [CoordW-1:0] in_point_x,
  input  logic [CoordW-1:0] in_point_y,
  input  logic [CoordW-1:0] in_point_z,
  input  logic [AlphaW-1:0] in_line_alpha,
  input  logic empty,
  input  logic pop,
  input  logic out_draw_line,
  input  logic [CoordW-1:0] out_start_x,
  input  logic [CoordW-1:0] out_start_y,
  input  logic [CoordW-1:0] out_end_x,
  input  logic [CoordW-1:0] out_end_y,
  input  logic [AlphaW-1:0] out_alpha_out,
  output int errors,
  output int pending
);

  logic [CfgDataW-1:0] matrix_regs [6];
  logic [CenterW-1:0] center_x, center_y;
  proj_res_t expected_lines [$];

  function automatic logic signed [31:0] mat_entry(int row, int col);
    logic [63:0] r;
    r = matrix_regs[row * 2 + col / 2];
    return (col % 2) ? r[63:32] : r[31:0];
  endfunction

  // coordinate times entry, full 64-bit product, shifted right by 8, low 32 bits
  function automatic logic [31:0] scaled(logic signed [31:0] c, logic signed [31:0] e);
    logic signed [63:0] a, b, p;
    a = c;
    b = e;
    p = a * b;
    return p[39:8];
  endfunction

  function automatic logic [31:0] transform_row(int row, logic signed [31:0] x,
                                                logic signed [31:0] y,
                                                logic signed [31:0] z);
    return mat_entry(row, 3) + scaled(x, mat_entry(row, 0)) + scaled(y, mat_entry(row, 1))
           + scaled(z, mat_entry(row, 2));
  endfunction

  function automatic proj_res_t project_point(logic signed [31:0] px, logic signed [31:0] py,
                                              logic signed [31:0] pz, logic [AlphaW-1:0] a);
    proj_res_t r;
    logic signed [31:0] x, y, z, depth, far_depth, nx, ny;
    logic signed [31:0] q_sx, q_sy, q_ex, q_ey;
    logic [31:0] cx, cy;
    x = px >>> 8;
    y = py >>> 8;
    z = pz >>> 8;
    depth = transform_row(2, x, y, z);
    r = '0;
    r.alpha = a;
    if (depth >= NEAR_LIMIT) begin
      nx = transform_row(0, x, y, z) << 8;
      ny = transform_row(1, x, y, z) << 8;
      far_depth = depth + FAR_OFFSET;  // may wrap negative, never zero
      cx = {20'd0, center_x};
      cy = {20'd0, center_y};
      // signed quotients, truncated toward zero
      q_sx = nx / depth;
      q_sy = ny / depth;
      q_ex = nx / far_depth;
      q_ey = ny / far_depth;
      r.draw = 1'b1;
      r.start_x = cx + q_sx;
      r.start_y = cy - q_sy;
      r.end_x = cx + q_ex;
      r.end_y = cy - q_ey;
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch: got %h expected %h", $time, field, got, want);
    errors++;
  endtask

  initial errors = 0;
  assign pending = expected_lines.size();

  always @(posedge clk) begin
    proj_res_t e;
    if (!rst_n) begin
      foreach (matrix_regs[i]) matrix_regs[i] <= '0;
      center_x <= '0;
      center_y <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CX: center_x <= cfg_data[CenterW-1:0];
          REG_CY: center_y <= cfg_data[CenterW-1:0];
          default: matrix_regs[cfg_index] <= cfg_data;
        endcase
      end
      if (push && !full)
        expected_lines.push_back(project_point(in_point_x, in_point_y, in_point_z,
                                               in_line_alpha));
      if (pop && !empty) begin
        if (expected_lines.size() == 0) begin
          $display("%0t: result transfer with nothing expected", $time);
          errors++;
        end else begin
          e = expected_lines.pop_front();
          if (out_draw_line !== e.draw)
            report_mismatch("draw_line", 32'(out_draw_line), 32'(e.draw));
          if (out_start_x !== e.start_x) report_mismatch("start_x", out_start_x, e.start_x);
          if (out_start_y !== e.start_y) report_mismatch("start_y", out_start_y, e.start_y);
          if (out_end_x !== e.end_x) report_mismatch("end_x", out_end_x, e.end_x);
          if (out_end_y !== e.end_y) report_mismatch("end_y", out_end_y, e.end_y);
          if (out_alpha_out !== e.alpha)
            report_mismatch("alpha_out", 32'(out_alpha_out), 32'(e.alpha));
        end
      end
    end
  end

endmodule

// File: test/fixed_point_line_projection_unit_tb.sv
// Testbench top for the fixed-point line projection unit: drives points and
// configuration phases, random stalls on both sides. Depends on flp_pkg,
// flp_projection_checker and the unit's RTL.
`timescale 1ns / 1ps
module fixed_point_line_projection_unit_tb;
  import flp_pkg::*;

  localparam int IdleLimit = 5000;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic push, full, empty, pop;
  logic [CoordW-1:0] in_point_x, in_point_y, in_point_z;
  logic [AlphaW-1:0] in_line_alpha;
  logic out_draw_line;
  logic [CoordW-1:0] out_start_x, out_start_y, out_end_x, out_end_y;
  logic [AlphaW-1:0] out_alpha_out;
  int errors, pending, idle_cycles;
  bit hold_req, tx_no_idle, rx_no_idle;

  always #1 clk = ~clk;

  fixed_point_line_projection_unit dut (.*);
  flp_projection_checker checker_i (.*);

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || cfg_we || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("fixed_point_line_projection_unit regression: fail");
      $finish;
    end
  end

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 2048) - 1024;
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
    endcase
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // m is row-major, four entries per row (cols 0..2 then translation)
  task automatic program_unit(logic [31:0] m [12], logic [CenterW-1:0] cx,
                              logic [CenterW-1:0] cy);
    for (int r = 0; r < 3; r++) begin
      write_reg(CfgIdxW'(2 * r), {m[4 * r + 1], m[4 * r]});
      write_reg(CfgIdxW'(2 * r + 1), {m[4 * r + 3], m[4 * r + 2]});
    end
    write_reg(REG_CX, {$urandom_range(0, 1) ? 32'hFFFF_F000 : 32'h0, 20'd0, cx});
    write_reg(REG_CY, {$urandom, 20'hFFFFF, cy});
    cfg_we <= 1'b0;
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [AlphaW-1:0] a);
    int gap;
    bit busy;
    if ($urandom_range(0, 39) == 0) tx_no_idle = !tx_no_idle;
    gap = tx_no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_point_x <= x;
    in_point_y <= y;
    in_point_z <= z;
    in_line_alpha <= a;
    // full only changes at the rising edge, so the falling edge shows its value there
    do begin
      @(negedge clk);
      busy = full;
      @(posedge clk);
    end while (busy);
  endtask

  task automatic send_random(int n);
    repeat (n) send_point(rand_value(), rand_value(), rand_value(),
                          AlphaW'($urandom_range(0, 511)));
    push <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic random_matrix(output logic [31:0] m [12]);
    foreach (m[i]) m[i] = rand_value();
    if ($urandom_range(0, 2) != 0) m[11] = $urandom_range(0, 32'h0010_0000);
  endtask

  // receiver: random pop gaps, one long hold-off on request
  initial begin
    int gap;
    bit busy;
    pop <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (400) @(posedge clk);
      end
      if ($urandom_range(0, 39) == 0) rx_no_idle = !rx_no_idle;
      gap = rx_no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do begin
        @(negedge clk);
        busy = empty;
        @(posedge clk);
      end while (busy);
    end
  end

  initial begin
    logic [31:0] m [12];
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    push <= 1'b0;
    in_point_x <= '0;
    in_point_y <= '0;
    in_point_z <= '0;
    in_line_alpha <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration: depth is zero, nothing is drawn
    send_random(20);
    drain();

    // unit scale: entry 256 passes a coordinate through
    m = '{32'd256, 0, 0, 0, 0, 32'd256, 0, 0, 0, 0, 32'd256, 0};
    program_unit(m, 12'd2048, 12'd1024);
    send_point(0, 0, 32'd1024 << 8, 9'd0);  // depth exactly at the near limit
    send_point(32'd5 << 16, 32'd7 << 16, 32'd1023 << 8, 9'd256);  // just below
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 9'd511);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 9'd257);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'd1);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 9'd128);
    send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0040_0000, 9'd255);
    send_point(0, 0, 0, 9'd256);
    send_point(32'h7FFF_FF00, 32'h0, 32'h0004_0000, 9'd3);  // X<<8 lands just below the signed maximum
    push <= 1'b0;
    drain();

    // far depth wraps past the signed maximum
    m = '{32'd256, 0, 0, 0, 0, 32'd256, 0, 0, 0, 0, 32'd256, 32'h7FFF_F800};
    program_unit(m, 12'd4095, 12'd0);
    send_point(32'h0100_0000, 32'hFF00_0000, 0, 9'd7);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0007_FF00, 9'd100);
    send_point(32'h8000_0000, 32'h8000_0000, 32'hFFF8_0000, 9'd200);
    push <= 1'b0;
    drain();

    // extreme entries, full centers; the receiver stalls for a while here
    foreach (m[i]) m[i] = (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    m[11] = 32'h7FFF_F800;
    program_unit(m, 12'd4095, 12'd4095);
    hold_req = 1'b1;
    send_random(300);
    drain();

    m = '{default: 32'd0};
    program_unit(m, 12'd0, 12'd0);
    send_random(50);
    drain();

    repeat (4) begin
      random_matrix(m);
      program_unit(m, 12'($urandom), 12'($urandom));
      send_random(330);
      drain();
    end

    repeat (60) @(posedge clk);
    if (errors == 0) $display("fixed_point_line_projection_unit regression: pass");
    else $display("fixed_point_line_projection_unit regression: fail");
    $finish;
  end

endmodule
